[rtl/owscr_pkg.sv]
package owscr_pkg;

  typedef enum logic [2:0] {
    REQ_SLOT      = 3'd0,
    REQ_LOAD      = 3'd1,
    REQ_BUS_RESET = 3'd2,
    REQ_LINK_ERR  = 3'd3,
    REQ_NO_RESP   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    PH_RECEIVE = 2'd0,
    PH_AWAIT   = 2'd1,
    PH_RESPOND = 2'd2,
    PH_CRC     = 2'd3
  } phase_e;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Result word as it leaves the control logic; the response bit itself is
  // picked from the buffer read data one stage later when use_mem is set.
  typedef struct packed {
    logic       reply;
    logic       use_mem;
    logic [2:0] bit_pos;
    logic       cmd_ready;
    logic [7:0] cmd_byte;
    logic       error;
    logic       app_reset;
  } res_t;

  // Dallas CRC-8, reflected, one data byte folded in.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/owscr_ram.sv]
module owscr_ram #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/owscr_ctrl.sv]
module owscr_ctrl #(
  parameter int Depth = 16,
  parameter int AddrW = 4,
  parameter int LenW  = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [2:0]          req_type_i,
  input  logic                master_bit_i,
  input  logic [7:0]          resp_byte_i,
  input  logic                resp_last_i,
  output owscr_pkg::res_t     res_o,
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [7:0]          mem_wdata_o,
  output logic [AddrW-1:0]    mem_raddr_o
);

  import owscr_pkg::*;

  localparam logic [LenW-1:0] DepthL = LenW'(Depth);

  phase_e          phase_q, phase_d;
  logic [2:0]      bit_idx_q, bit_idx_d;
  logic [7:0]      shift_q, shift_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] byte_q, byte_d;
  logic [7:0]      crc_q, crc_d;

  req_e            req;
  logic [7:0]      shift_new;
  logic [LenW-1:0] byte_inc;
  logic            last_bit;

  assign req       = req_e'(req_type_i);
  assign shift_new = shift_q | (8'(master_bit_i) << bit_idx_q);
  assign byte_inc  = byte_q + LenW'(1);
  assign last_bit  = (bit_idx_q == 3'd7);

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    len_d     = len_q;
    byte_d    = byte_q;
    crc_d     = crc_q;
    case (req)
      REQ_SLOT: begin
        if (phase_q == PH_RECEIVE) begin
          bit_idx_d = bit_idx_q + 3'd1;
          if (last_bit) begin
            shift_d = '0;
            len_d   = '0;
            byte_d  = '0;
            crc_d   = '0;
            phase_d = PH_AWAIT;
          end else begin
            shift_d = shift_new;
          end
        end else if (phase_q == PH_AWAIT || !master_bit_i) begin
          phase_d   = PH_RECEIVE;
          bit_idx_d = '0;
          shift_d   = '0;
          len_d     = '0;
          byte_d    = '0;
          crc_d     = '0;
        end else if (phase_q == PH_RESPOND) begin
          bit_idx_d = bit_idx_q + 3'd1;
          if (last_bit) begin
            byte_d = byte_inc;
            if (byte_inc >= len_q) begin
              byte_d  = '0;
              phase_d = PH_CRC;
            end
          end
        end else begin
          bit_idx_d = bit_idx_q + 3'd1;
          if (last_bit) begin
            phase_d   = PH_RECEIVE;
            bit_idx_d = '0;
            shift_d   = '0;
            len_d     = '0;
            byte_d    = '0;
            crc_d     = '0;
          end
        end
      end
      REQ_LOAD: begin
        if (phase_q == PH_AWAIT) begin
          if (len_q >= DepthL) begin
            phase_d   = PH_RECEIVE;
            bit_idx_d = '0;
            shift_d   = '0;
            len_d     = '0;
            byte_d    = '0;
            crc_d     = '0;
          end else begin
            len_d = len_q + LenW'(1);
            crc_d = crc_fold(crc_q, resp_byte_i);
            if (resp_last_i) begin
              phase_d   = PH_RESPOND;
              bit_idx_d = '0;
              byte_d    = '0;
            end
          end
        end
      end
      REQ_BUS_RESET, REQ_LINK_ERR: begin
        phase_d   = PH_RECEIVE;
        bit_idx_d = '0;
        shift_d   = '0;
        len_d     = '0;
        byte_d    = '0;
        crc_d     = '0;
      end
      REQ_NO_RESP: begin
        if (phase_q == PH_AWAIT) begin
          phase_d   = PH_RECEIVE;
          bit_idx_d = '0;
          shift_d   = '0;
          len_d     = '0;
          byte_d    = '0;
          crc_d     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Outputs: result word and buffer access.
  always_comb begin
    res_o       = '0;
    res_o.bit_pos = bit_idx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = len_q[AddrW-1:0];
    mem_wdata_o = resp_byte_i;
    mem_raddr_o = byte_q[AddrW-1:0];
    case (req)
      REQ_SLOT: begin
        res_o.reply = master_bit_i;
        if (phase_q == PH_RECEIVE) begin
          if (last_bit) begin
            res_o.cmd_ready = 1'b1;
            res_o.cmd_byte  = shift_new;
          end
        end else if (phase_q == PH_AWAIT || !master_bit_i) begin
          res_o.error = 1'b1;
        end else if (phase_q == PH_RESPOND) begin
          res_o.use_mem = 1'b1;
        end else begin
          res_o.reply = crc_q[bit_idx_q];
        end
      end
      REQ_LOAD: begin
        if (phase_q == PH_AWAIT) begin
          if (len_q >= DepthL) begin
            res_o.error = 1'b1;
          end else begin
            mem_we_o = accept_i;
          end
        end
      end
      REQ_BUS_RESET: res_o.app_reset = 1'b1;
      REQ_LINK_ERR:  res_o.error = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_RECEIVE;
      bit_idx_q <= '0;
      shift_q   <= '0;
      len_q     <= '0;
      byte_q    <= '0;
      crc_q     <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      len_q     <= len_d;
      byte_q    <= byte_d;
      crc_q     <= crc_d;
    end
  end

endmodule

[rtl/one_wire_slave_command_responder.sv]
// A result word passes through stage one and then the output register.
// One word per cycle unless the output stalls; one read port serves every slot.
// A word is accepted while a result waits at the output if stage one is empty.
// Reset (rst_ni low, asynchronous) returns to receive with all counters and
// the CRC cleared; the response buffer is not cleared and holds no valid bits.
module one_wire_slave_command_responder #(
  parameter int RESPONSE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] req_type_i,
  input  logic       master_bit_i,
  input  logic [7:0] resp_byte_i,
  input  logic       resp_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       reply_bit_o,
  output logic       cmd_ready_o,
  output logic [7:0] cmd_byte_o,
  output logic       error_o,
  output logic       app_reset_o
);

  import owscr_pkg::*;

  // Address width of the buffer, and a length width that can hold the depth itself.
  localparam int AddrW = (RESPONSE_DEPTH > 1) ? $clog2(RESPONSE_DEPTH) : 1;
  localparam int LenW  = $clog2(RESPONSE_DEPTH + 1);

  logic             accept;
  res_t             res;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  // Stage one holds the result word alongside the buffer read, which lands
  // in the memory's own output register on the same edge.
  logic s1_valid_q;
  res_t s1_res_q;
  logic s1_move;

  logic       out_valid_q;
  logic       reply_q;
  logic       cmd_ready_q;
  logic [7:0] cmd_byte_q;
  logic       error_q;
  logic       app_reset_q;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  owscr_ctrl #(
    .Depth (RESPONSE_DEPTH),
    .AddrW (AddrW),
    .LenW  (LenW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .master_bit_i (master_bit_i),
    .resp_byte_i  (resp_byte_i),
    .resp_last_i  (resp_last_i),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr)
  );

  // Writes happen only on loads; every accepted word reads, but only a slot
  // uses its read data, so a read beside a load's write is never used.
  owscr_ram #(
    .Depth (RESPONSE_DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // In the respond phase, the reply bit is taken from the buffer word just read.
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      reply_q     <= s1_res_q.use_mem ? mem_rdata[s1_res_q.bit_pos] : s1_res_q.reply;
      cmd_ready_q <= s1_res_q.cmd_ready;
      cmd_byte_q  <= s1_res_q.cmd_byte;
      error_q     <= s1_res_q.error;
      app_reset_q <= s1_res_q.app_reset;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reply_bit_o = reply_q;
  assign cmd_ready_o = cmd_ready_q;
  assign cmd_byte_o  = cmd_byte_q;
  assign error_o     = error_q;
  assign app_reset_o = app_reset_q;

`ifndef NO_ASSERTIONS
  // A word in stage one with an empty output register moves on at once.
  a_s1_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_q)
    else $error("stage one word was not moved to the output");

  // A completed command never coincides with an error or a bus reset.
  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cmd_ready_o && (error_o || app_reset_o)) && !(error_o && app_reset_o))
    else $error("conflicting status flags in one result word");

  // The command byte is zero unless a command has just completed.
  a_cmd_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cmd_ready_o |-> cmd_byte_o == 8'd0)
    else $error("command byte set without cmd_ready");
`endif

endmodule

[tb/one_wire_slave_command_responder_tb.sv]
module one_wire_slave_command_responder_tb;
  import owscr_pkg::*;

  localparam int RESP_DEPTH = 16;

  // The request codes above the last named one have no meaning to the block
  // and must be ignored by it.
  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

  // One input word as the host presents it, and one result word as the
  // block returns it.
  typedef struct packed {
    logic [2:0] req;
    logic       mbit;
    logic [7:0] data;
    logic       last;
  } slave_word_t;

  typedef struct packed {
    logic       reply;
    logic       cmd_ready;
    logic [7:0] cmd_byte;
    logic       error;
    logic       app_reset;
  } slave_reply_t;

  // Every input is given a known value from the very start of the run.
  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [2:0] req_type_i   = '0;
  logic       master_bit_i = 1'b0;
  logic [7:0] resp_byte_i  = '0;
  logic       resp_last_i  = 1'b0;
  logic       out_ready_i  = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       reply_bit_o;
  logic       cmd_ready_o;
  logic [7:0] cmd_byte_o;
  logic       error_o;
  logic       app_reset_o;

  one_wire_slave_command_responder #(
    .RESPONSE_DEPTH(RESP_DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .master_bit_i(master_bit_i),
    .resp_byte_i (resp_byte_i),
    .resp_last_i (resp_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .reply_bit_o (reply_bit_o),
    .cmd_ready_o (cmd_ready_o),
    .cmd_byte_o  (cmd_byte_o),
    .error_o     (error_o),
    .app_reset_o (app_reset_o)
  );

  // Words waiting to be sent, and the results that the accepted words must
  // produce, oldest first.
  slave_word_t  pending_words[$];
  slave_reply_t expected_replies[$];
  int           words_queued = 0;
  int           mismatches   = 0;

  // Percentages of cycles in which the sender holds back a word and the
  // receiver refuses a result.
  int send_idle_pct = 31;
  int recv_idle_pct = 55;

  slave_word_t  next_word;
  slave_reply_t seen_reply;
  slave_reply_t wanted_reply;

  // Our own copy of the slave's command-layer state.
  phase_e      link_phase = PH_RECEIVE;
  logic [2:0]  bit_idx    = '0;
  logic [7:0]  cmd_sr     = '0;
  logic [7:0]  resp_mem[RESP_DEPTH];
  int unsigned resp_len   = 0;
  int unsigned byte_idx   = 0;
  logic [7:0]  crc_acc    = '0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The Dallas CRC-8 taken one data bit at a time: the feedback bit is the
  // low CRC bit against the incoming data bit, and it folds in the reflected
  // polynomial after the shift.
  function automatic logic [7:0] crc8_fold_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ 8'h8C;
      end
    end
    return c;
  endfunction

  // An error, a bus reset and the end of a response all put the link back
  // into the receive phase. The response store keeps what it holds.
  task automatic drop_link_state();
    link_phase = PH_RECEIVE;
    bit_idx    = '0;
    cmd_sr     = '0;
    resp_len   = 0;
    byte_idx   = 0;
    crc_acc    = '0;
  endtask

  // Works out the result of one accepted word, advances our copy of the
  // state and files the result as expected.
  task automatic model_slave_word(input slave_word_t w);
    slave_reply_t r;
    logic [7:0]   b;
    r = '0;
    case (w.req)
      REQ_SLOT: begin
        r.reply = w.mbit;
        if (link_phase == PH_RECEIVE) begin
          // Command bits arrive least significant first.
          cmd_sr  = cmd_sr | (8'(w.mbit) << bit_idx);
          bit_idx = bit_idx + 3'd1;
          if (bit_idx == '0) begin
            r.cmd_ready = 1'b1;
            r.cmd_byte  = cmd_sr;
            cmd_sr      = '0;
            resp_len    = 0;
            byte_idx    = 0;
            crc_acc     = '0;
            link_phase  = PH_AWAIT;
          end
        end else if (link_phase == PH_AWAIT || !w.mbit) begin
          // A slot while the host has not answered yet, or a master 0
          // during transmission, is a protocol error.
          r.error = 1'b1;
          drop_link_state();
        end else if (link_phase == PH_RESPOND) begin
          b       = resp_mem[byte_idx];
          r.reply = b[bit_idx];
          bit_idx = bit_idx + 3'd1;
          if (bit_idx == '0) begin
            byte_idx++;
            if (byte_idx >= resp_len) begin
              byte_idx   = 0;
              link_phase = PH_CRC;
            end
          end
        end else begin
          r.reply = crc_acc[bit_idx];
          bit_idx = bit_idx + 3'd1;
          if (bit_idx == '0) begin
            drop_link_state();
          end
        end
      end
      REQ_LOAD: begin
        if (link_phase == PH_AWAIT) begin
          if (resp_len >= RESP_DEPTH) begin
            // The response store is full: overflow.
            r.error = 1'b1;
            drop_link_state();
          end else begin
            resp_mem[resp_len] = w.data;
            resp_len++;
            crc_acc = crc8_fold_byte(crc_acc, w.data);
            if (w.last) begin
              link_phase = PH_RESPOND;
              bit_idx    = '0;
              byte_idx   = 0;
            end
          end
        end
      end
      REQ_BUS_RESET: begin
        r.app_reset = 1'b1;
        drop_link_state();
      end
      REQ_LINK_ERR: begin
        r.error = 1'b1;
        drop_link_state();
      end
      REQ_NO_RESP: begin
        if (link_phase == PH_AWAIT) begin
          drop_link_state();
        end
      end
      default: begin
      end
    endcase
    expected_replies.push_back(r);
  endtask

  task automatic queue_word(input logic [2:0] req, input logic mbit, input logic [7:0] data,
                            input logic last);
    slave_word_t w;
    w.req  = req;
    w.mbit = mbit;
    w.data = data;
    w.last = last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Slots and loads carry random values in the fields that they do not use,
  // so that the block is seen to ignore them.
  task automatic queue_slot(input logic mbit);
    queue_word(REQ_SLOT, mbit, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic queue_load(input logic [7:0] data, input logic last);
    queue_word(REQ_LOAD, 1'($urandom_range(1)), data, last);
  endtask

  task automatic queue_command(input logic [7:0] cmd);
    for (int i = 0; i < 8; i++) begin
      queue_slot(cmd[i]);
    end
  endtask

  // A word that the block must ignore while it is transmitting.
  task automatic queue_ignored_word();
    case ($urandom_range(2))
      0: queue_load(8'($urandom_range(255)), 1'($urandom_range(1)));
      1: queue_word(REQ_NO_RESP, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
      default: queue_word(REQ_UNUSED_FIRST + 3'($urandom_range(2)), 1'($urandom_range(1)),
                          8'($urandom_range(255)), 1'($urandom_range(1)));
    endcase
  endtask

  // Queues one exchange with the master. Most are well formed, a command
  // followed by a response, so that transmission and the CRC are reached
  // often. Every kind leaves the link in the receive phase, so that the next
  // exchange starts in step with the block.
  task automatic queue_random_exchange();
    int kind;
    int n;
    int nbits;
    int cut;
    int pick;
    kind = $urandom_range(99);
    if (kind < 12) begin
      // Noise of any kind, then a bus reset or a link error to resync.
      repeat ($urandom_range(1, 6)) begin
        queue_word(3'($urandom_range(7)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end
      queue_word($urandom_range(1) ? REQ_BUS_RESET : REQ_LINK_ERR, 1'($urandom_range(1)),
                 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      queue_command(8'($urandom_range(255)));
      if (kind < 22) begin
        queue_word(REQ_NO_RESP, 1'($urandom_range(1)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end else if (kind < 30) begin
        // The master starts a slot before the host has answered.
        queue_slot(1'($urandom_range(1)));
      end else if (kind < 37) begin
        // Fill the store without marking the end, then one load too many.
        repeat (RESP_DEPTH) queue_load(8'($urandom_range(255)), 1'b0);
        queue_load(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (kind < 44) begin
        // Bytes are loaded, then the host changes its mind.
        repeat ($urandom_range(1, RESP_DEPTH)) queue_load(8'($urandom_range(255)), 1'b0);
        queue_word(REQ_NO_RESP, 1'($urandom_range(1)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end else begin
        // A full response: mostly short, sometimes long, now and then the
        // whole store.
        pick = $urandom_range(19);
        if (pick < 14) begin
          n = $urandom_range(1, 3);
        end else if (pick < 18) begin
          n = $urandom_range(4, RESP_DEPTH - 1);
        end else begin
          n = RESP_DEPTH;
        end
        for (int i = 0; i < n; i++) begin
          queue_load(8'($urandom_range(255)), i == n - 1);
        end
        nbits = 8 * n + 8;
        cut   = ($urandom_range(99) < 15) ? $urandom_range(nbits - 1) : nbits;
        for (int i = 0; i < nbits; i++) begin
          if (i == cut) begin
            // Transmission is broken off by a master 0, a bus reset or a
            // link error, in a data bit or in a CRC bit.
            case ($urandom_range(2))
              0: queue_slot(1'b0);
              1: queue_word(REQ_BUS_RESET, 1'($urandom_range(1)), 8'($urandom_range(255)),
                            1'($urandom_range(1)));
              default: queue_word(REQ_LINK_ERR, 1'($urandom_range(1)),
                                  8'($urandom_range(255)), 1'($urandom_range(1)));
            endcase
            break;
          end
          if ($urandom_range(99) < 4) begin
            queue_ignored_word();
          end
          queue_slot(1'b1);
        end
      end
    end
  endtask

  task automatic note_mismatch(input string what, input slave_reply_t want,
                               input slave_reply_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected reply=%0b cmd_ready=%0b cmd_byte=%02h error=%0b app_reset=%0b",
               what, want.reply, want.cmd_ready, want.cmd_byte, want.error, want.app_reset);
      $display("               got      reply=%0b cmd_ready=%0b cmd_byte=%02h error=%0b app_reset=%0b",
               got.reply, got.cmd_ready, got.cmd_byte, got.error, got.app_reset);
    end
  endtask

  task automatic wait_until_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_replies.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Driver. A word that has been accepted is passed to the prediction at the
  // edge that accepts it; then the next word, if any, is put up unless the
  // sender chooses to idle. Valid stays high with an unchanged word until the
  // block takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        next_word = '{req_type_i, master_bit_i, resp_byte_i, resp_last_i};
        model_slave_word(next_word);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          in_valid_i   <= 1'b1;
          req_type_i   <= next_word.req;
          master_bit_i <= next_word.mbit;
          resp_byte_i  <= next_word.data;
          resp_last_i  <= next_word.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each result word taken from the block is checked against the
  // oldest expectation; the receiver stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_reply = {reply_bit_o, cmd_ready_o, cmd_byte_o, error_o, app_reset_o};
        if (expected_replies.size() == 0) begin
          note_mismatch("no result expected", '0, seen_reply);
        end else begin
          wanted_reply = expected_replies.pop_front();
          if (seen_reply !== wanted_reply) begin
            note_mismatch("wrong field", wanted_reply, seen_reply);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening: requests outside a command, the spare codes, then
    // two commands at the extremes of the byte, one dropped by the host and
    // one cut short by a slot while the answer is still awaited.
    queue_word(REQ_BUS_RESET, 1'b1, 8'hFF, 1'b1);
    queue_word(REQ_LINK_ERR, 1'b0, 8'h00, 1'b0);
    for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++) begin
      queue_word(3'(c), 1'b1, 8'hFF, 1'b1);
    end
    queue_word(REQ_LOAD, 1'b0, 8'hFF, 1'b1);
    queue_word(REQ_NO_RESP, 1'b1, 8'h00, 1'b0);
    queue_command(8'h00);
    queue_word(REQ_NO_RESP, 1'b0, 8'h00, 1'b0);
    queue_command(8'hFF);
    queue_slot(1'b1);

    // Random exchanges in three stretches: a busy receiver, a slow sender,
    // and neither holding back.
    while (words_queued < 540) queue_random_exchange();
    wait_until_drained();
    send_idle_pct = 55;
    recv_idle_pct = 31;
    while (words_queued < 1060) queue_random_exchange();
    wait_until_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (words_queued < 1580) queue_random_exchange();
    wait_until_drained();

    // Allow for the result pipeline and a little more, so that a stray
    // extra result would still be caught.
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
